>>> rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg: shared definitions for the bitmap free-bit allocator
// sizes of the allocation map, action codes, memory port types and helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

  // map geometry
  localparam int MAP_BYTES = 4096;
  localparam int MAP_BITS  = MAP_BYTES * 8;
  localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  // index field width and the bytes a find may look at
  localparam int IDX_W      = 15;
  localparam int IDX_BYTES  = (1 << IDX_W) / 8;
  localparam int SCAN_BYTES = (MAP_BYTES < IDX_BYTES) ? MAP_BYTES : IDX_BYTES;

  // action codes
  localparam logic [1:0] ACT_FIND = 2'd0;
  localparam logic [1:0] ACT_USE  = 2'd1;
  localparam logic [1:0] ACT_FREE = 2'd2;

  typedef logic [7:0]    map_byte_t;
  typedef logic [AW-1:0] map_addr_t;

  // write port of the map memory
  typedef struct packed {
    logic      en;
    map_addr_t addr;
    map_byte_t data;
  } map_wr_t;

  // position of the lowest zero bit in a byte (byte must not be all ones)
  function automatic logic [2:0] first_zero(input map_byte_t b);
    logic [2:0] pos;
    logic       hit;
    pos = 3'd0;
    hit = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (!hit && !b[j]) begin
        pos = 3'(j);
        hit = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bfa_map_ram.sv
// ----------------------------------------------------------------------------
// bfa_map_ram: allocation map storage
// one write port and one registered read port, one byte per entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfa_map_ram (
  input  wire               clk,
  input  bfa_pkg::map_wr_t  wr,
  input  bfa_pkg::map_addr_t raddr,
  output bfa_pkg::map_byte_t rdata
);

  bfa_pkg::map_byte_t mem [bfa_pkg::MAP_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/bitmap_free_bit_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_free_bit_allocator: find-first-zero bitmap allocator
// keeps a 4096-byte allocation map in a single-port-read memory and serves
// find, mark-used and mark-free requests one at a time
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one request word: action on tuser, bit index on tdata
//   m_* channel returns exactly one result word per request: free index on
//   tdata, the no-free-bit flag on tuser
//   bit j of map byte i stands for index i*8+j; 0 means free
// after reset
//   a clearing pass writes zero to every map byte, one byte a cycle;
//   s_tready stays low until it is done
// steps, accept to m_tvalid
//   mark-used / mark-free: read, modify and write back, result
//   unused action code: straight to the result, plain zero result
//   find: reads map bytes from byte zero, one byte per cycle, up to the
//   first byte with a free bit or through the last byte, then the result;
//   the pace is set by the single read port of the map memory
// throughput
//   one request in flight at a time; the next is taken as soon as the
//   result is loaded into the output register
// stalls
//   the result waits in the output register while m_tready is low; a new
//   result is held back until that register drains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_free_bit_allocator (
  input  wire         clk,
  input  wire         rst,
  // request stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [14:0] bit_index, [15] zero
  input  wire  [1:0]  s_tuser,   // [1:0] action
  // result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // [14:0] free_index, [15] zero
  output logic        m_tuser    // [0] none_free
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t                       state;
  bfa_pkg::map_addr_t           cnt;      // clear address, then scan address
  logic [1:0]                   act;
  bfa_pkg::map_addr_t           baddr;    // byte of a set or clear
  logic [2:0]                   bpos;     // bit within that byte
  logic [bfa_pkg::IDX_W-1:0]    res_index;
  logic                         res_none;

  // request fields
  logic [1:0]                   in_act;
  logic [bfa_pkg::IDX_W-1:0]    in_idx;
  bfa_pkg::map_addr_t           in_byte;
  logic                         in_range;
  logic                         accept;

  // memory port
  bfa_pkg::map_wr_t             wr;
  bfa_pkg::map_addr_t           raddr;
  bfa_pkg::map_byte_t           rdata;
  bfa_pkg::map_byte_t           bmask;
  logic                         last_scan;

  assign in_act   = s_tuser;
  assign in_idx   = s_tdata[14:0];
  assign in_byte  = bfa_pkg::map_addr_t'({17'd0, in_idx} >> 3);
  assign in_range = {17'd0, in_idx} < 32'(bfa_pkg::MAP_BITS);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign bmask     = 8'd1 << bpos;
  assign last_scan = (cnt == bfa_pkg::map_addr_t'(bfa_pkg::SCAN_BYTES - 1));

  // read address: the next byte while scanning, else the byte the new
  // request points at (byte zero for a find)
  always_comb begin
    if (state == S_SCAN) begin
      raddr = cnt + bfa_pkg::map_addr_t'(1);
    end else if (in_act == bfa_pkg::ACT_FIND) begin
      raddr = '0;
    end else begin
      raddr = in_byte;
    end
  end

  // write port: clearing sweep, or write back of a modified byte
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = baddr;
    wr.data = rdata;
    unique case (state)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = cnt;
        wr.data = '0;
      end
      S_RMW: begin
        wr.en   = 1'b1;
        wr.addr = baddr;
        wr.data = (act == bfa_pkg::ACT_USE) ? (rdata | bmask) : (rdata & ~bmask);
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  bfa_map_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output register: load a finished result, or drain on handshake
      if (state == S_RESULT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (cnt == bfa_pkg::map_addr_t'(bfa_pkg::MAP_BYTES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + bfa_pkg::map_addr_t'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            act       <= in_act;
            baddr     <= in_byte;
            bpos      <= in_idx[2:0];
            cnt       <= '0;
            res_index <= '0;
            res_none  <= 1'b0;
            if (in_act == bfa_pkg::ACT_FIND) begin
              state <= S_SCAN;
            end else if ((in_act == bfa_pkg::ACT_USE || in_act == bfa_pkg::ACT_FREE)
                         && in_range) begin
              state <= S_RMW;
            end else begin
              // unused code or index past the map: plain zero result
              state <= S_RESULT;
            end
          end
        end
        S_RMW: begin
          state <= S_RESULT;
        end
        S_SCAN: begin
          // rdata holds map byte cnt
          if (rdata != 8'hFF) begin
            res_index <= bfa_pkg::IDX_W'({cnt, bfa_pkg::first_zero(rdata)});
            state     <= S_RESULT;
          end else if (last_scan) begin
            res_none <= 1'b1;
            state    <= S_RESULT;
          end else begin
            cnt <= cnt + bfa_pkg::map_addr_t'(1);
          end
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {1'b0, res_index};
            m_tuser <= res_none;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker: port-level checks for the bitmap free-bit allocator
// watches both streams over time; bound to the top level below
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfa_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata,
  input wire        m_tuser
);

  // no stale result survives a reset
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a request is worked on alone: no second word right behind it
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in flight");

  // a failed find never carries an index
  a_none_free_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[14:0] == 15'd0))
    else $error("none_free result with nonzero index");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // after an accepted request the request channel is not open beside a stuck result
  a_in_needs_room: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !(m_tvalid && $past(m_tvalid && !m_tready) && s_tready))
    else $error("request channel open with a stuck result");

endmodule

bind bitmap_free_bit_allocator bfa_checker u_bfa_checker (.*);

`default_nettype wire

>>> test/bitmap_alloc_checker.sv
// ----------------------------------------------------------------------------
// bitmap_alloc_checker: result checker for the bitmap free-bit allocator
// keeps its own copy of the allocation map, predicts one result per accepted
// request word and compares every returned word field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_alloc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [14:0] bit_index, [15] zero
  input  logic [1:0]  s_tuser,   // [1:0] action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [14:0] free_index, [15] zero
  input  logic        m_tuser,   // [0] none_free
  output int          failures,
  output int          outstanding
);

  typedef struct packed {
    logic                      none_free;
    logic [bfa_pkg::IDX_W-1:0] free_index;
  } alloc_result_t;

  bfa_pkg::map_byte_t occupancy [bfa_pkg::MAP_BYTES];
  alloc_result_t      pending_results [$];

  // lowest free index among the bytes a find may reach
  function automatic alloc_result_t lowest_free_slot();
    alloc_result_t r;
    r = '0;
    r.none_free = 1'b1;
    for (int i = 0; i < bfa_pkg::SCAN_BYTES; i++) begin
      if (occupancy[i] != 8'hFF) begin
        for (int j = 7; j >= 0; j--) begin
          if (!occupancy[i][j]) r.free_index = bfa_pkg::IDX_W'(i * 8 + j);
        end
        r.none_free = 1'b0;
        return r;
      end
    end
    return r;
  endfunction

  function automatic alloc_result_t apply_request(input logic [1:0] act,
                                                  input logic [bfa_pkg::IDX_W-1:0] idx);
    alloc_result_t r;
    int            byte_at;
    r = '0;
    byte_at = int'(idx >> 3);
    case (act)
      bfa_pkg::ACT_FIND: begin
        r = lowest_free_slot();
      end
      bfa_pkg::ACT_USE: begin
        if (byte_at < bfa_pkg::MAP_BYTES) occupancy[byte_at][idx[2:0]] = 1'b1;
      end
      bfa_pkg::ACT_FREE: begin
        if (byte_at < bfa_pkg::MAP_BYTES) occupancy[byte_at][idx[2:0]] = 1'b0;
      end
      default: begin
        // unused code: map untouched, zero result
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (rst) begin
      for (int i = 0; i < bfa_pkg::MAP_BYTES; i++) occupancy[i] = '0;
      pending_results.delete();
      failures    <= 0;
      outstanding <= 0;
    end else begin
      // results first: a request accepted at this edge cannot answer yet
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[bfa_pkg::IDX_W-1:0]};
        if (pending_results.size() == 0) begin
          $display("%0t: result word with none expected, actual free_index %0d none_free %0b",
                   $time, got.free_index, got.none_free);
          failures <= failures + 1;
        end else begin
          want = pending_results.pop_front();
          if (got.free_index !== want.free_index) begin
            $display("%0t: free_index mismatch, expected %0d actual %0d",
                     $time, want.free_index, got.free_index);
            failures <= failures + 1;
          end else if (got.none_free !== want.none_free) begin
            $display("%0t: none_free mismatch, expected %0b actual %0b",
                     $time, want.none_free, got.none_free);
            failures <= failures + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(apply_request(s_tuser, s_tdata[bfa_pkg::IDX_W-1:0]));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for the bitmap free-bit allocator
// drives directed and random find / mark-used / mark-free requests with
// random idling on both streams, fills the first map bytes so finds skip
// over them, and leaves result checking to bitmap_alloc_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // action code the block must answer with an all-zero result
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int MAX_INDEX    = (1 << bfa_pkg::IDX_W) - 1;
  localparam int SPARSE_ITEMS = 50;     // random words on a sparse map
  localparam int DENSE_ITEMS  = 30;     // random words on a filled prefix
  localparam int FILL_BITS    = 32;     // first four bytes marked used
  localparam int HOLD_AT      = 30;     // result count that starts the long stall
  localparam int HOLD_CYCLES  = 300;    // receiver hold-off length
  // a full scan, the clearing pass after reset and the receiver hold-off
  // must all fit under this limit with ample margin
  localparam int STALL_LIMIT  = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // [14:0] bit_index, [15] zero
  logic [1:0]  s_tuser  = '0;   // [1:0] action

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [14:0] free_index, [15] zero
  logic        m_tuser;         // [0] none_free

  int          failures;
  int          outstanding;
  int          results_taken = 0;
  int          stall_cycles  = 0;

  always #2 clk = ~clk;

  bitmap_free_bit_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  bitmap_alloc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // offer one request word, optionally after a random idle gap, and return
  // at the edge that accepts it; tvalid is left high so back-to-back words
  // never lower and raise it in the same step
  task automatic send_word(input logic [1:0] act, input logic [bfa_pkg::IDX_W-1:0] idx,
                           input bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, idx};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
  endtask

  // one random request; on a filled prefix uses dominate and most indices
  // land near its edge so finds move around it, on a sparse map most
  // indices land in the first bytes so finds vary
  task automatic random_request(input bit full_map, input bit quiet);
    int                        roll;
    logic [1:0]                act;
    logic [bfa_pkg::IDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    if (full_map) begin
      act = (roll < 25) ? bfa_pkg::ACT_FIND : (roll < 55) ? bfa_pkg::ACT_FREE :
            (roll < 95) ? bfa_pkg::ACT_USE  : ACT_UNUSED;
      idx = ($urandom_range(0, 9) < 8) ? bfa_pkg::IDX_W'($urandom_range(0, 47))
                                        : bfa_pkg::IDX_W'($urandom_range(0, MAX_INDEX));
    end else begin
      act = (roll < 35) ? bfa_pkg::ACT_FIND : (roll < 70) ? bfa_pkg::ACT_USE :
            (roll < 95) ? bfa_pkg::ACT_FREE : ACT_UNUSED;
      idx = ($urandom_range(0, 9) < 7) ? bfa_pkg::IDX_W'($urandom_range(0, 63))
                                        : bfa_pkg::IDX_W'($urandom_range(0, MAX_INDEX));
    end
    send_word(act, idx, quiet);
  endtask

  // result side: random readiness per word, a quiet stretch every 40 words,
  // and one long hold-off so the block backs up and stalls its input
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = (results_taken % 40 < 10) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_taken++;
      if (results_taken == HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // count cycles in which neither stream moves a word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("bitmap_free_bit_allocator regression: fail");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty map, unused code, redundant set and clear,
    // a full first byte, both ends of the index range
    send_word(bfa_pkg::ACT_FIND, 15'd0,     1'b0);   // empty map answers 0
    send_word(ACT_UNUSED,        15'h7FFF,  1'b0);
    send_word(bfa_pkg::ACT_USE,  15'd0,     1'b0);
    send_word(bfa_pkg::ACT_USE,  15'd0,     1'b1);   // already used
    send_word(bfa_pkg::ACT_FIND, 15'd0,     1'b0);
    for (int b = 1; b < 8; b++) send_word(bfa_pkg::ACT_USE, bfa_pkg::IDX_W'(b), 1'b1);
    send_word(bfa_pkg::ACT_FIND, 15'd0,     1'b0);   // byte 0 full, skips to 8
    send_word(bfa_pkg::ACT_FREE, 15'd5,     1'b0);
    send_word(bfa_pkg::ACT_FREE, 15'd5,     1'b0);   // already free
    send_word(bfa_pkg::ACT_FIND, 15'd0,     1'b1);
    send_word(bfa_pkg::ACT_USE,  15'h7FFF,  1'b0);
    send_word(bfa_pkg::ACT_FIND, 15'h7FFF,  1'b0);   // index ignored on a find
    send_word(bfa_pkg::ACT_FREE, 15'h7FFF,  1'b0);
    send_word(bfa_pkg::ACT_FREE, 15'd0,     1'b1);
    send_word(bfa_pkg::ACT_FIND, 15'd0,     1'b0);
    send_word(ACT_UNUSED,        15'd0,     1'b0);
    send_word(bfa_pkg::ACT_USE,  15'h4000,  1'b0);
    send_word(bfa_pkg::ACT_FREE, 15'h4000,  1'b0);

    // random on a sparse map; the long hold-off falls in here
    for (int n = 0; n < SPARSE_ITEMS; n++) random_request(1'b0, n % 32 < 8);

    // mark the first bytes used, then a find must look past them
    for (int b = 0; b < FILL_BITS; b++) begin
      send_word(bfa_pkg::ACT_USE, bfa_pkg::IDX_W'(b), 1'b1);
    end
    send_word(bfa_pkg::ACT_FIND, 15'd0,  1'b0);
    send_word(bfa_pkg::ACT_FREE, 15'd17, 1'b0);
    send_word(bfa_pkg::ACT_FIND, 15'd0,  1'b0);      // the freed bit comes first
    send_word(bfa_pkg::ACT_USE,  15'd17, 1'b0);
    send_word(bfa_pkg::ACT_FIND, 15'd0,  1'b0);

    // random around the filled prefix
    for (int n = 0; n < DENSE_ITEMS; n++) random_request(1'b1, n % 32 < 8);

    s_tvalid <= 1'b0;
    // one edge so the last accepted word shows up as outstanding
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (failures == 0 && outstanding == 0) begin
      $display("bitmap_free_bit_allocator regression: pass");
    end else begin
      $display("bitmap_free_bit_allocator regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bfa_pkg.sv
rtl/bfa_map_ram.sv
rtl/bitmap_free_bit_allocator.sv
rtl/bfa_checker.sv
test/bitmap_alloc_checker.sv
test/testbench.sv
